>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/mcw_pkg.sv
package mcw_pkg;

  localparam int NUM_MODULES = 16;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int CMP_W       = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int COUNT_W     = 5;
  localparam int MAX_REPORTS = 16;

  localparam logic [1:0] MODE_KICK  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  localparam logic [1:0] KIND_KICK_OK = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic clear;
    logic step;
  } mcw_cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SUM  = 3'b100
  } mcw_state_t;

endpackage

>>> hw/rtl/mcw_cell.sv
module mcw_cell
  import mcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  mcw_cell_ctrl_t       ctrl,
  input  logic                 kick,
  input  logic [TIME_BITS-1:0] now,
  input  logic [31:0]          timeout,
  input  logic                 token_in,
  output logic                 token_out,
  output logic                 hit
);

  logic                 registered;
  logic [TIME_BITS-1:0] stamp;
  logic                 token;
  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;

  always_ff @(posedge clk) begin
    if (rst) begin
      registered <= 1'b0;
      token      <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        registered <= 1'b0;
      end else if (kick) begin
        registered <= 1'b1;
      end
      if (ctrl.step) begin
        token <= token_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (kick) begin
      stamp <= now;
    end
  end

  assign elapsed   = now - stamp;
  assign expired   = CMP_W'(elapsed) >= CMP_W'(timeout);
  assign token_out = token;
  assign hit       = token & registered & expired;

endmodule

>>> hw/rtl/multi_channel_watchdog_top.sv
// Kick and error results appear in the output register in the cycle after the input beat.
// A tick advances the seconds counter and gives no result.
// A check walks a token down the module cells, one cell per cycle unless the output stalls,
// and then emits the summary with the count of expired modules.
// Synchronous reset clears enable, all marks and the seconds counter and sets the timeout to 1.
`include "assert_macros.svh"

module multi_channel_watchdog_top
  import mcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [3:0]  module_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [3:0]  timed_out_module,
  output logic [4:0]  timeout_count,
  output logic        last
);

  mcw_state_t           state, state_next;
  logic                 enable;
  logic [31:0]          timeout;
  logic [TIME_BITS-1:0] seconds_now;
  logic [IDX_W-1:0]     scan_idx;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;

  logic                 slot_free;
  logic                 accept;
  logic                 start;
  logic                 step;
  logic                 kick_fire;
  logic                 load;
  logic [1:0]           load_kind;
  logic [3:0]           load_module;
  logic [4:0]           load_count;
  logic                 load_last;
  logic                 cur_hit;
  logic                 idx_bad;

  mcw_cell_ctrl_t       cell_ctrl;
  logic [NUM_MODULES:0] chain;
  logic [NUM_MODULES-1:0] tokens;
  logic [NUM_MODULES-1:0] hits;
  logic [NUM_MODULES-1:0] kick_sel;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign idx_bad   = 32'(module_index) >= NUM_MODULES;
  assign cur_hit   = |hits;

  assign cell_ctrl.clear = cfg_valid && cfg_ready && (cfg_index == REG_ENABLE) && !cfg_data[0];
  assign cell_ctrl.step  = start || step;
  assign chain[0]        = start;

  genvar g;
  generate
    for (g = 0; g < NUM_MODULES; g++) begin : g_cell
      assign kick_sel[g] = kick_fire && (32'(module_index) == g);
      mcw_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (cell_ctrl),
        .kick      (kick_sel[g]),
        .now       (seconds_now),
        .timeout   (timeout),
        .token_in  (chain[g]),
        .token_out (chain[g+1]),
        .hit       (hits[g])
      );
      assign tokens[g] = chain[g+1];
    end
  endgenerate

  always_comb begin
    state_next  = state;
    count_next  = count;
    start       = 1'b0;
    step        = 1'b0;
    kick_fire   = 1'b0;
    load        = 1'b0;
    load_kind   = KIND_ERROR;
    load_module = 4'd0;
    load_count  = 5'd0;
    load_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept && (mode == MODE_KICK || mode == MODE_CHECK)) begin
          if (!enable) begin
            load = 1'b1;
          end else if (mode == MODE_KICK) begin
            load = 1'b1;
            if (!idx_bad) begin
              kick_fire = 1'b1;
              load_kind = KIND_KICK_OK;
            end
          end else begin
            start      = 1'b1;
            count_next = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (slot_free) begin
          step = 1'b1;
          if (cur_hit) begin
            if (count != '1) begin
              count_next = count + 1'b1;
            end
            if (32'(count) < MAX_REPORTS) begin
              load        = 1'b1;
              load_kind   = KIND_REPORT;
              load_module = 4'(scan_idx);
              load_last   = 1'b0;
            end
          end
          if (scan_idx == IDX_W'(NUM_MODULES - 1)) begin
            state_next = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (slot_free) begin
          load       = 1'b1;
          load_kind  = KIND_SUMMARY;
          load_count = count;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enable      <= 1'b0;
      timeout     <= 32'd1;
      seconds_now <= '0;
      scan_idx    <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ENABLE:  enable  <= cfg_data[0];
          REG_TIMEOUT: timeout <= cfg_data;
          default:     enable  <= enable;
        endcase
      end
      if (accept && mode == MODE_TICK) begin
        seconds_now <= seconds_now + 1'b1;
      end
      if (start) begin
        scan_idx <= '0;
      end else if (step) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind             <= load_kind;
      timed_out_module <= load_module;
      timeout_count    <= load_count;
      last             <= load_last;
    end
  end

  `ASSERT_IMPLIES(a_token_one_in_scan, state == S_SCAN, $onehot(tokens), "scan token lost")
  `ASSERT_IMPLIES(a_token_at_index, state == S_SCAN, tokens[scan_idx], "token and index disagree")
  `ASSERT_IMPLIES(a_no_token_idle, state != S_SCAN, tokens == '0, "stray token outside scan")
  `ASSERT_IMPLIES(a_ready_only_idle, in_ready, state == S_IDLE, "input taken during check")

endmodule
